### rtl/krt_pkg.sv
// Shared types, field layouts and limits of the keyed record table.
package krt_pkg;

    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int KEY_W      = 14;
    localparam int PRICE_W    = 24;
    localparam int QTY_W      = 20;
    localparam int SLOT_W     = 6;
    localparam int ENTRIES_W  = 7;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 72;

    localparam logic [KEY_W-1:0]   KEY_MIN   = 14'd1;
    localparam logic [KEY_W-1:0]   KEY_MAX   = 14'd10000;
    localparam logic [PRICE_W-1:0] PRICE_MAX = 24'd10000000;
    localparam logic [QTY_W-1:0]   QTY_MAX   = 20'd1000000;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_LOOKUP = 3'd1,
        REQ_UPDATE = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_RANGE  = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_DUP        = 3'd2,
        ST_RANGE      = 3'd3,
        ST_FULL       = 3'd4,
        ST_NONE       = 3'd5,
        ST_BAD_WINDOW = 3'd6
    } t_status;

    typedef struct packed {
        logic [5:0]         pad;
        logic [PRICE_W-1:0] window_high;
        logic [PRICE_W-1:0] window_low;
        logic [QTY_W-1:0]   quantity_in;
        logic [PRICE_W-1:0] price_cents;
        logic [KEY_W-1:0]   key;
    } t_in_data;

    typedef struct packed {
        logic                 pad;
        logic [ENTRIES_W-1:0] entries;
        logic [SLOT_W-1:0]    rec_slot;
        logic [QTY_W-1:0]     rec_quantity;
        logic [PRICE_W-1:0]   rec_price;
        logic [KEY_W-1:0]     rec_key;
    } t_out_data;

    typedef struct packed {
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
        logic [KEY_W-1:0]   key;
    } t_rec;

    typedef struct packed {
        logic load;
        logic scan;
        logic shift;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic needs_scan;
        logic key_hit;
        logic is_delete;
        logic scan_end;
        logic shift_end;
        logic out_free;
    } t_stat;

endpackage

### rtl/krt_ctrl.sv
// Request sequencer of the keyed record table.
module krt_ctrl
    import krt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.needs_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.key_hit) begin
                    n_state = i_stat.is_delete ? S_SHIFT : S_FINISH;
                end else if (i_stat.scan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/krt_datapath.sv
// Record memory, scan and compaction pipeline, and result register.
module krt_datapath
    import krt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [REQ_W-1:0]      i_in_req,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_out_status,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_last
);

    t_rec r_mem [DEPTH];

    logic [CW-1:0] r_cnt;
    t_req          r_type;
    t_in_data      r_req;
    logic [CW-1:0] r_ptr;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_slot;
    t_rec          r_rd_rec;
    logic          r_pend_vld;
    logic [IW-1:0] r_pend_slot;
    t_rec          r_pend_rec;
    logic          r_out_vld;
    t_status       r_out_status;
    t_out_data     r_out;
    logic          r_out_last;

    t_req     w_in_type;
    t_in_data w_in;
    logic     w_in_bad_window;
    logic     w_range_mode;
    logic     w_price_in;
    logic     w_match;
    logic     w_key_hit;
    logic     w_out_free;
    logic     w_stall;
    logic     w_more;
    logic     w_rd_issue;
    logic     w_emit;
    logic     w_take;
    logic     w_shift_wr;
    logic     w_fin;
    logic     w_wr_en;
    logic [IW-1:0] w_wr_addr;
    t_rec     w_wr_rec;

    t_status       f_status;
    t_rec          f_rec;
    logic [IW-1:0] f_slot;
    logic          f_has_rec;
    logic [CW-1:0] f_count;
    logic          f_wr;
    logic [IW-1:0] f_wr_addr;
    t_rec          f_wr_rec;

    assign w_in_type       = t_req'(i_in_req);
    assign w_in            = t_in_data'(i_in_data);
    assign w_in_bad_window = (w_in.window_high > PRICE_MAX) ||
                             (w_in.window_high < w_in.window_low);

    assign w_range_mode = (r_type == REQ_RANGE);
    assign w_price_in   = (r_rd_rec.price >= r_req.window_low) &&
                          (r_rd_rec.price <= r_req.window_high);
    assign w_match      = r_rd_vld &&
                          (w_range_mode ? w_price_in : (r_rd_rec.key == r_req.key));
    assign w_key_hit    = !w_range_mode && w_match;
    assign w_out_free   = !r_out_vld || i_out_ready;
    assign w_stall      = w_range_mode && w_match && r_pend_vld && !w_out_free;
    assign w_more       = (r_ptr < r_cnt);
    assign w_rd_issue   = (i_cmd.scan && !w_key_hit && !w_stall && w_more) ||
                          (i_cmd.shift && w_more);
    assign w_emit       = i_cmd.scan && w_range_mode && w_match && r_pend_vld && w_out_free;
    assign w_take       = i_cmd.scan && w_match && !w_stall;
    assign w_shift_wr   = i_cmd.shift && r_rd_vld;
    assign w_fin        = i_cmd.finish && w_out_free;

    always_comb begin
        o_stat            = '0;
        o_stat.needs_scan = (w_in_type == REQ_INSERT) || (w_in_type == REQ_LOOKUP) ||
                            (w_in_type == REQ_UPDATE) || (w_in_type == REQ_DELETE) ||
                            ((w_in_type == REQ_RANGE) && !w_in_bad_window);
        o_stat.key_hit    = w_key_hit;
        o_stat.is_delete  = (r_type == REQ_DELETE);
        o_stat.scan_end   = !w_stall && !w_key_hit && !w_more;
        o_stat.shift_end  = !w_more && !r_rd_vld;
        o_stat.out_free   = w_out_free;
    end

    always_comb begin
        f_status  = ST_RANGE;
        f_rec     = r_pend_rec;
        f_slot    = r_pend_slot;
        f_has_rec = 1'b0;
        f_count   = r_cnt;
        f_wr      = 1'b0;
        f_wr_addr = r_pend_slot;
        f_wr_rec  = r_pend_rec;
        case (r_type)
            REQ_INSERT: begin
                if ((r_req.key < KEY_MIN) || (r_req.key > KEY_MAX)) begin
                    f_status = ST_RANGE;
                end else if (r_pend_vld) begin
                    f_status = ST_DUP;
                end else if ((r_req.price_cents > PRICE_MAX) ||
                             (r_req.quantity_in > QTY_MAX)) begin
                    f_status = ST_RANGE;
                end else if (r_cnt == CW'(DEPTH)) begin
                    f_status = ST_FULL;
                end else begin
                    f_status       = ST_OK;
                    f_rec.key      = r_req.key;
                    f_rec.price    = r_req.price_cents;
                    f_rec.quantity = r_req.quantity_in;
                    f_slot         = r_cnt[IW-1:0];
                    f_has_rec      = 1'b1;
                    f_count        = CW'(r_cnt + 1'b1);
                    f_wr           = 1'b1;
                    f_wr_addr      = r_cnt[IW-1:0];
                    f_wr_rec       = f_rec;
                end
            end
            REQ_LOOKUP: begin
                f_status  = r_pend_vld ? ST_OK : ST_NOT_FOUND;
                f_has_rec = r_pend_vld;
            end
            REQ_UPDATE: begin
                f_has_rec = r_pend_vld;
                if (!r_pend_vld) begin
                    f_status = ST_NOT_FOUND;
                end else if (r_req.quantity_in > QTY_MAX) begin
                    f_status = ST_RANGE;
                end else begin
                    f_status          = ST_OK;
                    f_rec.quantity    = r_req.quantity_in;
                    f_wr              = 1'b1;
                    f_wr_rec          = f_rec;
                end
            end
            REQ_DELETE: begin
                f_has_rec = r_pend_vld;
                if (r_pend_vld) begin
                    f_status = ST_OK;
                    f_count  = CW'(r_cnt - 1'b1);
                end else begin
                    f_status = ST_NOT_FOUND;
                end
            end
            REQ_RANGE: begin
                f_has_rec = r_pend_vld && !((r_req.window_high > PRICE_MAX) ||
                                            (r_req.window_high < r_req.window_low));
                if ((r_req.window_high > PRICE_MAX) ||
                    (r_req.window_high < r_req.window_low)) begin
                    f_status = ST_BAD_WINDOW;
                end else if (r_pend_vld) begin
                    f_status = ST_OK;
                end else begin
                    f_status = ST_NONE;
                end
            end
            default: begin
                f_status = ST_RANGE;
            end
        endcase
    end

    assign w_wr_en   = w_shift_wr || (w_fin && f_wr);
    assign w_wr_addr = w_shift_wr ? IW'(r_rd_slot - 1'b1) : f_wr_addr;
    assign w_wr_rec  = w_shift_wr ? r_rd_rec : f_wr_rec;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_rec;
        end
        if (w_rd_issue) begin
            r_rd_rec  <= r_mem[r_ptr[IW-1:0]];
            r_rd_slot <= r_ptr[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_vld   <= 1'b0;
                r_pend_vld <= 1'b0;
            end else begin
                r_rd_vld <= w_rd_issue || w_stall;
                if (w_take) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (w_fin) begin
                r_cnt <= f_count;
            end
            if (w_emit || w_fin) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= w_in_type;
            r_req  <= w_in;
            r_ptr  <= '0;
        end else if (w_rd_issue) begin
            r_ptr <= CW'(r_ptr + 1'b1);
        end
        if (w_take) begin
            r_pend_slot <= r_rd_slot;
            r_pend_rec  <= r_rd_rec;
        end
        if (w_emit) begin
            r_out_status       <= ST_OK;
            r_out_last         <= 1'b0;
            r_out.pad          <= 1'b0;
            r_out.entries      <= ENTRIES_W'(r_cnt);
            r_out.rec_slot     <= SLOT_W'(r_pend_slot);
            r_out.rec_quantity <= r_pend_rec.quantity;
            r_out.rec_price    <= r_pend_rec.price;
            r_out.rec_key      <= r_pend_rec.key;
        end else if (w_fin) begin
            r_out_status       <= f_status;
            r_out_last         <= 1'b1;
            r_out.pad          <= 1'b0;
            r_out.entries      <= ENTRIES_W'(f_count);
            r_out.rec_slot     <= f_has_rec ? SLOT_W'(f_slot) : '0;
            r_out.rec_quantity <= f_has_rec ? f_rec.quantity : '0;
            r_out.rec_price    <= f_has_rec ? f_rec.price : '0;
            r_out.rec_key      <= f_has_rec ? f_rec.key : '0;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out;
    assign o_out_last   = r_out_last;

endmodule

### rtl/keyed_record_table_unit.sv
// Top level of the keyed record table: linear-search record store with compaction.
//
//  channel  direction  ports                         transaction
//  s_axis   in         tvalid tready tdata tuser     one request
//  m_axis   out        tvalid tready tdata tuser     one result, tlast on the final one
//
//  A request walks the table through a single memory read port, one record a cycle
//  unless a range search is stalled at a match: lookup, update and insert stop at
//  the hit slot (every entry on a miss), a price range search reads every entry,
//  a delete finds its key, then shifts every later record down one slot. Bad windows
//  and unknown request codes skip the walk. A stalled result stalls a range search at
//  its next match; other requests wait only at their final result. Reset empties the table.
module keyed_record_table_unit
    import krt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key[13:0], price_cents[37:14], quantity_in[57:38], window_low[81:58],
    // window_high[105:82], zero[111:106]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rec_key[13:0], rec_price[37:14], rec_quantity[57:38], rec_slot[63:58],
    // entries[70:64], zero[71]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]   m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_cmd  w_cmd;
    t_stat w_stat;

    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    krt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_req     (s_axis_tuser),
        .i_in_data    (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

### rtl/krt_checker.sv
// Port-level checks on the keyed record table, bound to its top level.
module krt_checker
    import krt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser,
    input logic                  m_axis_tlast
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_mid_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ST_OK)
        else $error("non-final result without ok status");

    a_fail_no_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_DUP ||
            m_axis_tuser == ST_FULL || m_axis_tuser == ST_NONE ||
            m_axis_tuser == ST_BAD_WINDOW) |-> m_axis_tdata[13:0] == '0)
        else $error("failed request reports a record");

    a_ok_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_OK |->
            m_axis_tdata[13:0] >= KEY_MIN && m_axis_tdata[13:0] <= KEY_MAX)
        else $error("ok result with key out of range");

    a_entries_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'(DEPTH))
        else $error("entry count above table depth");

endmodule

bind keyed_record_table_unit krt_checker #(
    .DEPTH (DEPTH)
) u_krt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
